>>> rtl/plx_pkg.sv
// Package for the pseudocode lexer: token and beat types, kind codes,
// character classes and the keyword table. No dependencies.
`default_nettype none
package plx_pkg;

  localparam int POS_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_TOKENS = 3;
  localparam int NUM_KEYS = 19;

  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_IDENT = 5'd1;
  localparam logic [4:0] KIND_OPERATOR = 5'd17;
  localparam logic [4:0] KIND_STRING = 5'd18;
  localparam logic [4:0] KIND_EOF = 5'd19;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  // Keywords are left aligned: the first character sits in the top byte.
  localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
    {"Declare", 8'h00}, {"Assign", 16'h0}, {"Function"},
    {"Integer", 8'h00}, {"String", 16'h0}, {"Boolean", 8'h00},
    {"As", 48'h0}, {"Of", 48'h0}, {"Then", 32'h0}, {"To", 48'h0},
    {"Do", 48'h0}, {"Array", 24'h0}, {"Read", 32'h0}, {"Print", 24'h0},
    {"If", 48'h0}, {"Else", 32'h0}, {"For", 40'h0}, {"While", 24'h0},
    {"End", 40'h0}
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
    4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd2, 4'd2, 4'd4, 4'd2,
    4'd2, 4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3
  };
  localparam logic [4:0] KEY_KIND [NUM_KEYS] = '{
    5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd8, 5'd8,
    5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  op_char;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [1:0]              count;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } queue_port_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
           (c == ">") || (c == "<") || (c == "&") || (c == "|");
  endfunction

  // The caller saturates the length to 15 when it exceeds eight characters. Bytes at
  // or past the length are ignored in the compare.
  function automatic logic [4:0] classify(input logic [63:0] word, input logic [3:0] len);
    logic [4:0]  kind;
    logic [63:0] masked;
    masked = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len) begin
        masked[63 - 8*b -: 8] = word[63 - 8*b -: 8];
      end
    end
    kind = KIND_IDENT;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if ((len == KEY_LEN[i]) && (masked == KEY_TEXT[i])) begin
        kind = KEY_KIND[i];
      end
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

>>> rtl/plx_if.sv
// Stream interfaces for the pseudocode lexer: the character channel and the
// token channel, each with valid, ready and payload. No dependencies.
`default_nettype none
interface plx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_valid;
  logic       end_of_input;

  modport source (output valid, char_byte, char_valid, end_of_input, input ready);
  modport sink (input valid, char_byte, char_valid, end_of_input, output ready);
endinterface

interface plx_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  operator_char;
  logic        last_of_run;

  modport source (output valid, token_kind, token_start, token_length, operator_char,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_start, token_length, operator_char,
                last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/plx_front.sv
// Lexer front end: accepts character beats, tracks the lexer state and
// builds the bundle of tokens each beat causes. Depends on plx_pkg, plx_if.
`default_nettype none
module plx_front #(
  parameter int POS_WIDTH = plx_pkg::POS_WIDTH_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  plx_char_if.sink             char_in,
  input  wire                  queue_full,
  output plx_pkg::queue_port_t push
);
  import plx_pkg::*;

  localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_STR   = 4'b1000
  } mode_t;

  mode_t                mode, mode_next;
  logic [POS_WIDTH-1:0] position, position_next;
  logic [POS_WIDTH-1:0] token_begin, token_begin_next;
  logic [63:0]          word, word_next;
  bundle_t              bundle;
  logic                 accept;

  function automatic logic [15:0] low16(input logic [POS_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[15:0];
  endfunction

  function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] p);
    return (p == {POS_WIDTH{1'b1}}) ? p : p + 1'b1;
  endfunction

  function automatic logic [3:0] sat_len(input logic [POS_WIDTH-1:0] len);
    return (len > POS_WIDTH'(8)) ? 4'hF : len[3:0];
  endfunction

  function automatic token_t make_tok(input logic [4:0] kind, input logic [POS_WIDTH-1:0] start,
                                      input logic [POS_WIDTH-1:0] len, input logic [7:0] op);
    token_t t;
    t.kind = kind;
    t.start = low16(start);
    t.length = low16(len);
    t.op_char = op;
    return t;
  endfunction

  assign char_in.ready = !queue_full;
  assign accept = char_in.valid && char_in.ready;

  always_comb begin
    logic                 handled;
    logic [7:0]           c;
    logic [POS_WIDTH-1:0] len;
    logic [POS_WIDTH-1:0] idx;
    logic [1:0]           n;
    c = char_in.char_byte;
    mode_next = mode;
    position_next = position;
    token_begin_next = token_begin;
    word_next = word;
    bundle = '0;
    n = 2'd0;
    handled = 1'b0;
    len = position - token_begin;
    idx = len;
    if (char_in.char_valid) begin
      unique case (mode)
        MODE_IDLE: begin
          handled = 1'b0;
        end
        MODE_STR: begin
          if (c == CHAR_QUOTE) begin
            bundle.tok[n] = make_tok(KIND_STRING, token_begin, len, 8'h00);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            word_next = '0;
          end
          handled = 1'b1;
        end
        MODE_NUM: begin
          if (is_digit(c)) begin
            handled = 1'b1;
          end else begin
            bundle.tok[n] = make_tok(KIND_NUMBER, token_begin, len, 8'h00);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            word_next = '0;
          end
        end
        MODE_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            if (idx < POS_WIDTH'(8)) begin
              word_next = (word & ~(64'hFF << (6'd56 - {idx[2:0], 3'b000})))
                        | (64'(c) << (6'd56 - {idx[2:0], 3'b000}));
            end
            handled = 1'b1;
          end else begin
            bundle.tok[n] = make_tok(classify(word, sat_len(len)), token_begin, len, 8'h00);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            word_next = '0;
          end
        end
        default: begin
          handled = 1'b1;
        end
      endcase
      if (!handled) begin
        if (is_digit(c)) begin
          mode_next = MODE_NUM;
          token_begin_next = position;
        end else if (is_alpha(c)) begin
          mode_next = MODE_IDENT;
          token_begin_next = position;
          word_next = {c, 56'h0};
        end else if (is_op(c)) begin
          bundle.tok[n] = make_tok(KIND_OPERATOR, position, POS_WIDTH'(1), c);
          n = n + 2'd1;
        end else if (c == CHAR_QUOTE) begin
          mode_next = MODE_STR;
          token_begin_next = pos_inc(position);
        end
      end
      position_next = pos_inc(position);
    end
    if (char_in.end_of_input) begin
      len = position_next - token_begin_next;
      if (mode_next == MODE_NUM) begin
        bundle.tok[n] = make_tok(KIND_NUMBER, token_begin_next, len, 8'h00);
        n = n + 2'd1;
      end else if (mode_next == MODE_IDENT) begin
        bundle.tok[n] = make_tok(classify(word_next, sat_len(len)), token_begin_next, len,
                                 8'h00);
        n = n + 2'd1;
      end else if (mode_next == MODE_STR) begin
        bundle.tok[n] = make_tok(KIND_STRING, token_begin_next, len, 8'h00);
        n = n + 2'd1;
      end
      bundle.tok[n] = make_tok(KIND_EOF, position_next, '0, 8'h00);
      n = n + 2'd1;
      mode_next = MODE_IDLE;
      position_next = '0;
      token_begin_next = '0;
      word_next = '0;
    end
    bundle.count = n;
  end

  assign push.valid = accept && (bundle.count != 2'd0);
  assign push.bundle = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      position <= '0;
      token_begin <= '0;
      word <= '0;
    end else if (accept) begin
      mode <= mode_next;
      position <= position_next;
      token_begin <= token_begin_next;
      word <= word_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/plx_queue.sv
// Short queue of token bundles between the lexer front end and the token
// back end. Depends on plx_pkg.
`default_nettype none
module plx_queue (
  input  wire                       clk,
  input  wire                       rst,
  input  wire plx_pkg::queue_port_t push,
  output logic                      full,
  input  wire                       pop,
  output plx_pkg::queue_port_t      head
);
  import plx_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign do_pop = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.bundle = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/plx_back.sv
// Token back end: walks the head bundle of the queue and sends its tokens
// one beat at a time. Depends on plx_pkg, plx_if.
`default_nettype none
module plx_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire plx_pkg::queue_port_t head,
  output logic                      pop,
  plx_token_if.source               token_out
);
  import plx_pkg::*;

  logic [1:0] sub;
  token_t     tok;
  logic       last;
  logic       accept;

  assign tok = head.bundle.tok[sub];
  assign last = (sub == head.bundle.count - 2'd1);
  assign accept = token_out.valid && token_out.ready;
  assign pop = accept && last;

  assign token_out.valid = head.valid;
  assign token_out.token_kind = tok.kind;
  assign token_out.token_start = tok.start;
  assign token_out.token_length = tok.length;
  assign token_out.operator_char = tok.op_char;
  assign token_out.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (accept) begin
      sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pseudocode_lexer.sv
// Top level of the pseudocode lexer: front end, bundle queue and back end.
// Depends on plx_pkg, plx_if, plx_front, plx_queue, plx_back.
//
// Channel    Direction  Beat
// char_in    in         one character, its valid flag and end of input
// token_out  out        one token: kind, start, length, operator, last flag
//
// A character beat is taken every cycle while the bundle queue has room.
// Each token leaves in a beat of its own, so a beat that causes k tokens
// takes k output beats, each one paced by token_out.ready.
// Reset is synchronous and clears the lexer state and the queue.
// A stalled output fills the queue and then holds char_in.ready low.
`default_nettype none
module pseudocode_lexer #(
  parameter int POS_WIDTH = plx_pkg::POS_WIDTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  plx_char_if.sink    char_in,
  plx_token_if.source token_out
);
  import plx_pkg::*;

  queue_port_t push;
  queue_port_t head;
  logic        queue_full;
  logic        pop;

  plx_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .char_in(char_in),
    .queue_full(queue_full),
    .push(push)
  );

  plx_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(queue_full),
    .pop(pop),
    .head(head)
  );

  plx_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .pop(pop),
    .token_out(token_out)
  );

endmodule
`default_nettype wire
